FILE: sv/neutrino_pz_from_w_mass_macros.svh
// assertion macros shared by the neutrino pz reconstruction rtl
// no dependencies; included by the top level, the module that carries assertions
`ifndef NEUTRINO_PZ_FROM_W_MASS_MACROS_SVH
`define NEUTRINO_PZ_FROM_W_MASS_MACROS_SVH

// same-cycle implication, held off during reset
`define NUPZ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nupz same-cycle check failed");

// next-cycle implication, held off during reset
`define NUPZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nupz next-cycle check failed");

`endif

FILE: sv/nupz_pkg.sv
// shared types, constants and datapath step functions for the neutrino pz pipeline
// no dependencies; imported by every module of the block
package nupz_pkg;

    localparam int FRAC_BITS = 6;
    // 80.4 GeV rounded to the fixed point grid
    localparam logic [15:0] W_MASS_RESET = 16'(((804 << FRAC_BITS) + 5) / 10);
    // register index decoded from paddr[2]
    localparam logic [0:0] W_MASS_IDX = 1'b0;

    localparam int RAD_W     = 84;
    localparam int ROOT_BITS = 42;
    localparam int DIV_BITS  = 24;
    localparam int EN_BITS   = 24;
    localparam int EN_RAD_W  = 48;

    localparam logic signed [23:0] PZ_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] PZ_MIN = 24'sh800000;
    localparam logic [23:0]        EN_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [39:0] den;
        logic [18:0]        le;
        logic [18:0]        me;
        logic signed [19:0] mx;
        logic signed [19:0] my;
        logic               real_sol;
        logic               degen;
    } side_t;

    typedef struct packed {
        side_t            side;
        logic [RAD_W-1:0] rad;
    } radi_t;

    typedef struct packed {
        side_t                side;
        logic [ROOT_BITS-1:0] root;
    } root_t;

    typedef struct packed {
        logic signed [23:0] pz;
        logic [18:0]        me;
        logic signed [19:0] mx;
        logic signed [19:0] my;
        logic               real_sol;
        logic               degen;
    } pzres_t;

    typedef struct packed {
        logic signed [19:0] mx;
        logic signed [19:0] my;
        logic signed [23:0] pz;
        logic [23:0]        energy;
        logic               real_sol;
        logic               degen;
    } result_t;

    typedef struct packed {
        logic [RAD_W-1:0]     rem;
        logic [ROOT_BITS-1:0] root;
    } sq84_t;

    typedef struct packed {
        logic [EN_RAD_W-1:0] rem;
        logic [EN_BITS-1:0]  root;
    } sq48_t;

    typedef struct packed {
        logic [63:0]         rem;
        logic [DIV_BITS-1:0] q;
    } dv_t;

    // one bit of a restoring square root, remainder kept as x - r^2
    function automatic sq84_t sqrt84_step(input logic [RAD_W-1:0] rem,
                                          input logic [ROOT_BITS-1:0] r,
                                          input int bit_pos);
        sq84_t            res;
        logic [RAD_W-1:0] trial;
        trial    = (RAD_W'(r) << (bit_pos + 1)) | (RAD_W'(1) << (2 * bit_pos));
        res.rem  = rem;
        res.root = r;
        if (rem >= trial)
        begin
            res.rem  = rem - trial;
            res.root = r | (ROOT_BITS'(1) << bit_pos);
        end
        return res;
    endfunction

    function automatic sq48_t sqrt48_step(input logic [EN_RAD_W-1:0] rem,
                                          input logic [EN_BITS-1:0] r,
                                          input int bit_pos);
        sq48_t               res;
        logic [EN_RAD_W-1:0] trial;
        trial    = (EN_RAD_W'(r) << (bit_pos + 1)) | (EN_RAD_W'(1) << (2 * bit_pos));
        res.rem  = rem;
        res.root = r;
        if (rem >= trial)
        begin
            res.rem  = rem - trial;
            res.root = r | (EN_BITS'(1) << bit_pos);
        end
        return res;
    endfunction

    // one quotient bit of a restoring divide
    function automatic dv_t div_step(input logic [63:0] rem,
                                     input logic [DIV_BITS-1:0] q,
                                     input logic [39:0] d,
                                     input int bit_pos);
        dv_t         res;
        logic [63:0] trial;
        trial   = 64'(d) << bit_pos;
        res.rem = rem;
        res.q   = q;
        if (rem >= trial)
        begin
            res.rem = rem - trial;
            res.q   = q | (DIV_BITS'(1) << bit_pos);
        end
        return res;
    endfunction

endpackage

FILE: sv/neutrino_pz_from_w_mass.sv
// top level of the w-mass constrained neutrino pz reconstruction pipeline
// depends on nupz_pkg, nupz_front, nupz_root, nupz_div, nupz_energy and the macros header
//
// Takes one event per transaction: lepton px/py/pz/energy and missing px/py/energy,
// all GeV with six fraction bits. The block solves the W-mass constrained quadratic
// for the neutrino pz exactly in integer arithmetic, keeps the root of smaller
// magnitude (or the real part -b/2a when the discriminant is negative, clearing
// real_solution), rounds pz to nearest and saturates it to 24 bits, and returns
// nu_energy = round(sqrt(met_energy^2 + nu_pz^2)). When |lepton_pz| equals the
// lepton energy the leading coefficient vanishes: pz is 0 and degenerate is set.
// Throughput is one transaction per clock while the pipeline is not frozen. The
// stages run in order: 5 front stages of multiplies and adds, 42 square-root stages
// on the 84-bit discriminant, 28 stages for root selection and the 24-bit restoring
// divide, 27 stages for the energy square root, and the output register. The whole
// pipeline freezes only when a result is waiting at the output with another right
// behind it; a bubble at the tail keeps it moving. The w_mass register (byte address
// 0, resets to 80.4 GeV) should only be written while the pipeline is empty.
`include "neutrino_pz_from_w_mass_macros.svh"

module neutrino_pz_from_w_mass
    import nupz_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [19:0] lepton_px,
    input  logic signed [19:0] lepton_py,
    input  logic signed [19:0] lepton_pz,
    input  logic [18:0]        lepton_energy,
    input  logic signed [19:0] met_px,
    input  logic signed [19:0] met_py,
    input  logic [18:0]        met_energy,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [19:0] nu_px,
    output logic signed [19:0] nu_py,
    output logic signed [23:0] nu_pz,
    output logic [23:0]        nu_energy,
    output logic               real_solution,
    output logic               degenerate
);

    logic [15:0] w_mass_reg;

    logic    adv;
    logic    rad_valid, root_valid, pz_valid, tail_valid;
    radi_t   rad_data;
    root_t   root_data;
    pzres_t  pz_data;
    result_t tail_data;

    logic    out_valid_reg;
    result_t res_reg;

    // register write on the access phase of a write transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            w_mass_reg <= W_MASS_RESET;
        else if (psel && penable && pwrite && paddr[2:2] == W_MASS_IDX)
            w_mass_reg <= pwdata[15:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == W_MASS_IDX) ? {16'b0, w_mass_reg} : '0;

    // the pipeline holds only when the output is blocked and the tail has a result
    assign adv      = !(out_valid_reg && out_stall && tail_valid);
    assign in_stall = !adv;

    nupz_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_valid      (in_valid),
        .w_mass        (w_mass_reg),
        .lepton_px     (lepton_px),
        .lepton_py     (lepton_py),
        .lepton_pz     (lepton_pz),
        .lepton_energy (lepton_energy),
        .met_px        (met_px),
        .met_py        (met_py),
        .met_energy    (met_energy),
        .rad_valid     (rad_valid),
        .rad_data      (rad_data)
    );

    nupz_root u_root (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .rad_valid  (rad_valid),
        .rad_data   (rad_data),
        .root_valid (root_valid),
        .root_data  (root_data)
    );

    nupz_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .root_valid (root_valid),
        .root_data  (root_data),
        .pz_valid   (pz_valid),
        .pz_data    (pz_data)
    );

    nupz_energy u_energy (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .pz_valid  (pz_valid),
        .pz_data   (pz_data),
        .res_valid (tail_valid),
        .res_data  (tail_data)
    );

    // output register: reloads whenever it is empty or being taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || !out_stall)
            out_valid_reg <= tail_valid;
    end

    always_ff @(posedge clk)
    begin
        if ((!out_valid_reg || !out_stall) && tail_valid)
            res_reg <= tail_data;
    end

    assign out_valid     = out_valid_reg;
    assign nu_px         = res_reg.mx;
    assign nu_py         = res_reg.my;
    assign nu_pz         = res_reg.pz;
    assign nu_energy     = res_reg.energy;
    assign real_solution = res_reg.real_sol;
    assign degenerate    = res_reg.degen;

    // degenerate events carry pz zero and always a real discriminant
    `NUPZ_ASSERT_IMPLY(a_degen_pz_zero, clk, rst_n, out_valid && degenerate, nu_pz == '0 && real_solution)
    // a complex discriminant needs a nonzero leading coefficient
    `NUPZ_ASSERT_IMPLY(a_complex_not_degen, clk, rst_n, out_valid && !real_solution, !degenerate)
    // a result leaving the tail always lands in the output register
    `NUPZ_ASSERT_NEXT(a_tail_lands, clk, rst_n, tail_valid && adv, out_valid)

endmodule

FILE: sv/nupz_front.sv
// front end: products, quadratic coefficients and discriminant radicand, five stages
// depends on nupz_pkg
module nupz_front
    import nupz_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [15:0]        w_mass,
    input  logic signed [19:0] lepton_px,
    input  logic signed [19:0] lepton_py,
    input  logic signed [19:0] lepton_pz,
    input  logic [18:0]        lepton_energy,
    input  logic signed [19:0] met_px,
    input  logic signed [19:0] met_py,
    input  logic [18:0]        met_energy,
    output logic               rad_valid,
    output radi_t              rad_data
);

    typedef struct packed {
        logic [31:0]        mw2;
        logic signed [39:0] pxl;
        logic signed [39:0] pyl;
        logic signed [39:0] mx2;
        logic signed [39:0] my2;
        logic signed [39:0] lz2;
        logic signed [39:0] le2;
        logic signed [19:0] lz;
        logic signed [19:0] mx;
        logic signed [19:0] my;
        logic [18:0]        le;
        logic [18:0]        me;
    } f1_t;

    typedef struct packed {
        logic signed [42:0] a2;
        logic [39:0]        pt2;
        logic signed [39:0] den;
        logic signed [19:0] lz;
        logic signed [19:0] mx;
        logic signed [19:0] my;
        logic [18:0]        le;
        logic [18:0]        me;
    } f2_t;

    typedef struct packed {
        logic [41:0]        hh;
        logic [41:0]        hl;
        logic [41:0]        ll;
        logic [39:0]        t11;
        logic [39:0]        t10;
        logic [39:0]        t01;
        logic [39:0]        t00;
        logic [40:0]        xh;
        logic [40:0]        xl;
        logic               prod_neg;
        logic signed [39:0] den;
        logic signed [19:0] mx;
        logic signed [19:0] my;
        logic [18:0]        le;
        logic [18:0]        me;
    } f3_t;

    typedef struct packed {
        logic [RAD_W-1:0]   sq;
        logic [RAD_W-1:0]   t;
        logic signed [63:0] x;
        logic signed [39:0] den;
        logic signed [19:0] mx;
        logic signed [19:0] my;
        logic [18:0]        le;
        logic [18:0]        me;
    } f4_t;

    logic  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    f1_t   f1_reg, f1_next;
    f2_t   f2_reg, f2_next;
    f3_t   f3_reg, f3_next;
    f4_t   f4_reg, f4_next;
    radi_t f5_reg, f5_next;

    logic [41:0]        am;
    logic [19:0]        lzm;
    logic [38:0]        dm;
    logic [63:0]        xm;

    // stage 1: raw products
    always_comb
    begin
        f1_next.mw2 = 32'(w_mass) * 32'(w_mass);
        f1_next.pxl = 40'(met_px) * 40'(lepton_px);
        f1_next.pyl = 40'(met_py) * 40'(lepton_py);
        f1_next.mx2 = 40'(met_px) * 40'(met_px);
        f1_next.my2 = 40'(met_py) * 40'(met_py);
        f1_next.lz2 = 40'(lepton_pz) * 40'(lepton_pz);
        f1_next.le2 = 40'($signed({1'b0, lepton_energy})) * 40'($signed({1'b0, lepton_energy}));
        f1_next.lz  = lepton_pz;
        f1_next.mx  = met_px;
        f1_next.my  = met_py;
        f1_next.le  = lepton_energy;
        f1_next.me  = met_energy;
    end

    // stage 2: A' = mw^2 + 2(pt_met . pt_lep), pt^2 and den = lz^2 - E^2 (the leading coefficient, negated)
    always_comb
    begin
        f2_next.a2  = $signed({11'b0, f1_reg.mw2}) + ((43'(f1_reg.pxl) + 43'(f1_reg.pyl)) <<< 1);
        f2_next.pt2 = $unsigned(f1_reg.mx2 + f1_reg.my2);
        f2_next.den = f1_reg.lz2 - f1_reg.le2;
        f2_next.lz  = f1_reg.lz;
        f2_next.mx  = f1_reg.mx;
        f2_next.my  = f1_reg.my;
        f2_next.le  = f1_reg.le;
        f2_next.me  = f1_reg.me;
    end

    // stage 3: split partial products of the wide squares
    always_comb
    begin
        am  = f2_reg.a2[42] ? 42'(-f2_reg.a2) : f2_reg.a2[41:0];
        lzm = f2_reg.lz[19] ? 20'(-f2_reg.lz) : $unsigned(f2_reg.lz);
        dm  = f2_reg.den[39] ? 39'(-f2_reg.den) : f2_reg.den[38:0];
        f3_next.hh       = 42'(am[41:21]) * 42'(am[41:21]);
        f3_next.hl       = 42'(am[41:21]) * 42'(am[20:0]);
        f3_next.ll       = 42'(am[20:0]) * 42'(am[20:0]);
        f3_next.t11      = 40'(f2_reg.pt2[39:20]) * 40'(dm[38:20]);
        f3_next.t10      = 40'(f2_reg.pt2[39:20]) * 40'(dm[19:0]);
        f3_next.t01      = 40'(f2_reg.pt2[19:0]) * 40'(dm[38:20]);
        f3_next.t00      = 40'(f2_reg.pt2[19:0]) * 40'(dm[19:0]);
        f3_next.xh       = 41'(lzm) * 41'(am[41:21]);
        f3_next.xl       = 41'(lzm) * 41'(am[20:0]);
        f3_next.prod_neg = f2_reg.lz[19] ^ f2_reg.a2[42];
        f3_next.den      = f2_reg.den;
        f3_next.mx       = f2_reg.mx;
        f3_next.my       = f2_reg.my;
        f3_next.le       = f2_reg.le;
        f3_next.me       = f2_reg.me;
    end

    // stage 4: assemble A'^2, 4*pt^2*|den| and x = -(lz*A')
    always_comb
    begin
        xm = (64'(f3_reg.xh) << 21) + 64'(f3_reg.xl);
        f4_next.sq  = (RAD_W'(f3_reg.hh) << 42) + (RAD_W'(f3_reg.hl) << 22) + RAD_W'(f3_reg.ll);
        f4_next.t   = ((RAD_W'(f3_reg.t11) << 40)
                      + ((RAD_W'(f3_reg.t10) + RAD_W'(f3_reg.t01)) << 20)
                      + RAD_W'(f3_reg.t00)) << 2;
        f4_next.x   = f3_reg.prod_neg ? $signed(xm) : -$signed(xm);
        f4_next.den = f3_reg.den;
        f4_next.mx  = f3_reg.mx;
        f4_next.my  = f3_reg.my;
        f4_next.le  = f3_reg.le;
        f4_next.me  = f3_reg.me;
    end

    // stage 5: pick the radicand, flag complex and degenerate cases
    always_comb
    begin
        f5_next.side.x        = f4_reg.x;
        f5_next.side.den      = f4_reg.den;
        f5_next.side.le       = f4_reg.le;
        f5_next.side.me       = f4_reg.me;
        f5_next.side.mx       = f4_reg.mx;
        f5_next.side.my       = f4_reg.my;
        f5_next.side.real_sol = 1'b1;
        f5_next.side.degen    = (f4_reg.den == '0);
        if (!f4_reg.den[39])
        begin
            f5_next.rad = f4_reg.sq + f4_reg.t;
        end
        else if (f4_reg.sq < f4_reg.t)
        begin
            f5_next.rad           = '0;
            f5_next.side.real_sol = (f4_reg.le == '0);
        end
        else
        begin
            f5_next.rad = f4_reg.sq - f4_reg.t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg <= f1_next;
            f2_reg <= f2_next;
            f3_reg <= f3_next;
            f4_reg <= f4_next;
            f5_reg <= f5_next;
        end
    end

    assign rad_valid = v5_reg;
    assign rad_data  = f5_reg;

endmodule

FILE: sv/nupz_root.sv
// discriminant square root: one root bit per stage, floor result
// depends on nupz_pkg
module nupz_root
    import nupz_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  rad_valid,
    input  radi_t rad_data,
    output logic  root_valid,
    output root_t root_data
);

    logic                 v_reg    [ROOT_BITS];
    logic [RAD_W-1:0]     rem_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] r_reg    [ROOT_BITS];
    side_t                side_reg [ROOT_BITS];

    for (genvar g = 0; g < ROOT_BITS; g++)
    begin : g_step
        logic                 v_prev;
        logic [RAD_W-1:0]     rem_prev;
        logic [ROOT_BITS-1:0] r_prev;
        side_t                side_prev;
        sq84_t                sq_next;

        if (g == 0)
        begin : g_first
            assign v_prev    = rad_valid;
            assign rem_prev  = rad_data.rad;
            assign r_prev    = '0;
            assign side_prev = rad_data.side;
        end
        else
        begin : g_rest
            assign v_prev    = v_reg[g-1];
            assign rem_prev  = rem_reg[g-1];
            assign r_prev    = r_reg[g-1];
            assign side_prev = side_reg[g-1];
        end

        assign sq_next = sqrt84_step(rem_prev, r_prev, ROOT_BITS - 1 - g);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[g] <= 1'b0;
            else if (adv)
                v_reg[g] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[g]  <= sq_next.rem;
                r_reg[g]    <= sq_next.root;
                side_reg[g] <= side_prev;
            end
        end
    end

    assign root_valid     = v_reg[ROOT_BITS-1];
    assign root_data.side = side_reg[ROOT_BITS-1];
    assign root_data.root = r_reg[ROOT_BITS-1];

endmodule

FILE: sv/nupz_div.sv
// root selection and rounded divide by 2a, one quotient bit per stage, saturating
// depends on nupz_pkg
module nupz_div
    import nupz_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   root_valid,
    input  root_t  root_data,
    output logic   pz_valid,
    output pzres_t pz_data
);

    typedef struct packed {
        logic [39:0]        yh;
        logic [39:0]        yl;
        logic signed [63:0] x;
        logic signed [39:0] den;
        logic [18:0]        me;
        logic signed [19:0] mx;
        logic signed [19:0] my;
        logic               real_sol;
        logic               degen;
    } d1_t;

    typedef struct packed {
        logic signed [63:0] n;
        logic signed [39:0] den;
        logic [18:0]        me;
        logic signed [19:0] mx;
        logic signed [19:0] my;
        logic               real_sol;
        logic               degen;
    } d2_t;

    typedef struct packed {
        logic [39:0]        d;
        logic               ovf;
        logic               neg;
        logic [18:0]        me;
        logic signed [19:0] mx;
        logic signed [19:0] my;
        logic               real_sol;
        logic               degen;
    } dside_t;

    logic   v1_reg, v2_reg, v3_reg, vs_reg;
    d1_t    d1_reg, d1_next;
    d2_t    d2_reg, d2_next;
    dside_t d3_reg, d3_next;
    logic [63:0] rem3_reg, rem3_next;
    pzres_t sat_reg, sat_next;

    logic                v_reg    [DIV_BITS];
    logic [63:0]         rem_reg  [DIV_BITS];
    logic [DIV_BITS-1:0] q_reg    [DIV_BITS];
    dside_t              ds_reg   [DIV_BITS];

    logic signed [63:0] y;
    logic [62:0]        nm;
    logic [38:0]        dm;
    logic [DIV_BITS-1:0] q;
    dside_t             dl;

    // y = E*root as two partial products
    always_comb
    begin
        d1_next.yh       = 40'(root_data.side.le) * 40'(root_data.root[41:21]);
        d1_next.yl       = 40'(root_data.side.le) * 40'(root_data.root[20:0]);
        d1_next.x        = root_data.side.x;
        d1_next.den      = root_data.side.den;
        d1_next.me       = root_data.side.me;
        d1_next.mx       = root_data.side.mx;
        d1_next.my       = root_data.side.my;
        d1_next.real_sol = root_data.side.real_sol;
        d1_next.degen    = root_data.side.degen;
    end

    // numerator of smaller magnitude, tie goes to -b-s
    always_comb
    begin
        y = $signed((64'(d1_reg.yh) << 21) + 64'(d1_reg.yl));
        d2_next.n        = (d1_reg.x < 0 && y > 0) ? d1_reg.x + y : d1_reg.x - y;
        d2_next.den      = d1_reg.den;
        d2_next.me       = d1_reg.me;
        d2_next.mx       = d1_reg.mx;
        d2_next.my       = d1_reg.my;
        d2_next.real_sol = d1_reg.real_sol;
        d2_next.degen    = d1_reg.degen;
    end

    // round half away: (|n| + |den|) / (2|den|), overflow past the quotient width
    always_comb
    begin
        nm = d2_reg.n[63] ? 63'(-d2_reg.n) : d2_reg.n[62:0];
        dm = d2_reg.den[39] ? 39'(-d2_reg.den) : d2_reg.den[38:0];
        rem3_next        = 64'(nm) + 64'(dm);
        d3_next.d        = {dm, 1'b0};
        d3_next.ovf      = rem3_next >= (64'({dm, 1'b0}) << DIV_BITS);
        d3_next.neg      = d2_reg.n[63] ^ d2_reg.den[39];
        d3_next.me       = d2_reg.me;
        d3_next.mx       = d2_reg.mx;
        d3_next.my       = d2_reg.my;
        d3_next.real_sol = d2_reg.real_sol;
        d3_next.degen    = d2_reg.degen;
    end

    for (genvar g = 0; g < DIV_BITS; g++)
    begin : g_step
        logic                v_prev;
        logic [63:0]         rem_prev;
        logic [DIV_BITS-1:0] q_prev;
        dside_t              ds_prev;
        dv_t                 dv_next;

        if (g == 0)
        begin : g_first
            assign v_prev   = v3_reg;
            assign rem_prev = rem3_reg;
            assign q_prev   = '0;
            assign ds_prev  = d3_reg;
        end
        else
        begin : g_rest
            assign v_prev   = v_reg[g-1];
            assign rem_prev = rem_reg[g-1];
            assign q_prev   = q_reg[g-1];
            assign ds_prev  = ds_reg[g-1];
        end

        assign dv_next = div_step(rem_prev, q_prev, ds_prev.d, DIV_BITS - 1 - g);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[g] <= 1'b0;
            else if (adv)
                v_reg[g] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[g] <= dv_next.rem;
                q_reg[g]   <= dv_next.q;
                ds_reg[g]  <= ds_prev;
            end
        end
    end

    // sign, saturation, degenerate override
    always_comb
    begin
        q  = q_reg[DIV_BITS-1];
        dl = ds_reg[DIV_BITS-1];
        if (dl.degen)
            sat_next.pz = '0;
        else if (dl.neg)
            sat_next.pz = (dl.ovf || q > 24'd8388608) ? PZ_MIN : -$signed(q);
        else
            sat_next.pz = (dl.ovf || q > 24'd8388607) ? PZ_MAX : $signed(q);
        sat_next.me       = dl.me;
        sat_next.mx       = dl.mx;
        sat_next.my       = dl.my;
        sat_next.real_sol = dl.real_sol;
        sat_next.degen    = dl.degen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vs_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= root_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vs_reg <= v_reg[DIV_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_reg   <= d1_next;
            d2_reg   <= d2_next;
            d3_reg   <= d3_next;
            rem3_reg <= rem3_next;
            sat_reg  <= sat_next;
        end
    end

    assign pz_valid = vs_reg;
    assign pz_data  = sat_reg;

endmodule

FILE: sv/nupz_energy.sv
// neutrino energy sqrt(met_e^2 + pz^2): squares, one root bit per stage, round and saturate
// depends on nupz_pkg
module nupz_energy
    import nupz_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  logic    pz_valid,
    input  pzres_t  pz_data,
    output logic    res_valid,
    output result_t res_data
);

    typedef struct packed {
        logic signed [23:0] pz;
        logic signed [19:0] mx;
        logic signed [19:0] my;
        logic               real_sol;
        logic               degen;
    } eside_t;

    logic                v1_reg, v2_reg, vr_reg;
    logic [EN_RAD_W-1:0] ap2_reg, me2_reg, sum_reg, sum_next;
    eside_t              e1_reg, e1_next, e2_reg;
    result_t             out_reg, out_next;
    logic [23:0]         apz;

    logic                v_reg    [EN_BITS];
    logic [EN_RAD_W-1:0] rem_reg  [EN_BITS];
    logic [EN_BITS-1:0]  r_reg    [EN_BITS];
    eside_t              es_reg   [EN_BITS];

    logic [EN_BITS:0]    rounded;

    assign apz      = pz_data.pz[23] ? 24'(-pz_data.pz) : $unsigned(pz_data.pz);
    assign sum_next = ap2_reg + me2_reg;

    always_comb
    begin
        e1_next.pz       = pz_data.pz;
        e1_next.mx       = pz_data.mx;
        e1_next.my       = pz_data.my;
        e1_next.real_sol = pz_data.real_sol;
        e1_next.degen    = pz_data.degen;
    end

    for (genvar g = 0; g < EN_BITS; g++)
    begin : g_step
        logic                v_prev;
        logic [EN_RAD_W-1:0] rem_prev;
        logic [EN_BITS-1:0]  r_prev;
        eside_t              es_prev;
        sq48_t               sq_next;

        if (g == 0)
        begin : g_first
            assign v_prev   = v2_reg;
            assign rem_prev = sum_reg;
            assign r_prev   = '0;
            assign es_prev  = e2_reg;
        end
        else
        begin : g_rest
            assign v_prev   = v_reg[g-1];
            assign rem_prev = rem_reg[g-1];
            assign r_prev   = r_reg[g-1];
            assign es_prev  = es_reg[g-1];
        end

        assign sq_next = sqrt48_step(rem_prev, r_prev, EN_BITS - 1 - g);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[g] <= 1'b0;
            else if (adv)
                v_reg[g] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[g] <= sq_next.rem;
                r_reg[g]   <= sq_next.root;
                es_reg[g]  <= es_prev;
            end
        end
    end

    // round to nearest: bump when the remainder exceeds the root
    always_comb
    begin
        rounded = (rem_reg[EN_BITS-1] > EN_RAD_W'(r_reg[EN_BITS-1]))
                  ? (EN_BITS+1)'(r_reg[EN_BITS-1]) + 1'b1
                  : (EN_BITS+1)'(r_reg[EN_BITS-1]);
        out_next.energy   = rounded[EN_BITS] ? EN_MAX : rounded[EN_BITS-1:0];
        out_next.pz       = es_reg[EN_BITS-1].pz;
        out_next.mx       = es_reg[EN_BITS-1].mx;
        out_next.my       = es_reg[EN_BITS-1].my;
        out_next.real_sol = es_reg[EN_BITS-1].real_sol;
        out_next.degen    = es_reg[EN_BITS-1].degen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vr_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= pz_valid;
            v2_reg <= v1_reg;
            vr_reg <= v_reg[EN_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ap2_reg <= EN_RAD_W'(apz) * EN_RAD_W'(apz);
            me2_reg <= EN_RAD_W'(pz_data.me) * EN_RAD_W'(pz_data.me);
            e1_reg  <= e1_next;
            sum_reg <= sum_next;
            e2_reg  <= e1_reg;
            out_reg <= out_next;
        end
    end

    assign res_valid = vr_reg;
    assign res_data  = out_reg;

endmodule
